@@ src/pab_pkg.sv @@
// shared types and constants for the pixel alpha blend block
package pab_pkg;

   // pixel formats
   localparam logic FMT_RGB  = 1'b0;
   localparam logic FMT_RGBA = 1'b1;

   // numerator bits of the over-rule quotient, one divider cell per bit
   localparam int NUM_W = 16;

   // front pipeline depth, sets the width of the front valid pipeline
   localparam int FRONT_STAGES = 5;

   // register map index
   typedef enum logic [1:0] {
      REG_SRC_FMT = 2'd0,
      REG_DST_FMT = 2'd1,
      REG_GALPHA  = 2'd2
   } pab_reg_type;

   // how a pixel is resolved
   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_MIX,
      KIND_OVER
   } pab_kind_type;

   // input word
   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic       row_end_in;
   } pab_req_type;

   // result word
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       row_end_out;
   } pab_rsp_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic       src_fmt;
      logic       dst_fmt;
      logic [7:0] galpha;
   } pab_cfg_type;

   // data handed from cell to cell; index 0 red, 1 green, 2 blue, 3 alpha
   typedef struct packed {
      logic                        div;
      logic [7:0]                  oa;
      logic [2:0][7:0]             rem;
      logic [2:0][NUM_W-1:0]       work;
      logic [3:0][7:0]             fixed;
      logic                        row_end;
   } pab_cell_type;

endpackage

@@ src/pixel_alpha_blend.sv @@
// top level: register port, front pipeline, divider cell row and result register
//
//   channel   handshake            payload
//   input     start / busy         req_data (pab_req_type)
//   result    rsp_valid strobe     rsp_data (pab_rsp_type)
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// one pixel is taken every cycle; busy stays low
// each word that is taken passes through 5 front stages,
// 16 divider cells (one quotient bit each) and the result register
// synchronous reset clears the pipeline valid bits and the registers
// the receiver cannot stall, so nothing in the pipeline ever holds
module pixel_alpha_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pab_pkg::pab_req_type req_data,
   output logic                 rsp_valid,
   output pab_pkg::pab_rsp_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import pab_pkg::*;

   logic        src_fmt_ff, src_fmt_in;
   logic        dst_fmt_ff, dst_fmt_in;
   logic [7:0]  galpha_ff, galpha_in;
   pab_cfg_type cfg;
   pab_reg_type reg_sel;
   logic        wr_en;

   logic         chain_valid [0:NUM_W];
   pab_cell_type chain_data  [0:NUM_W];

   logic         rsp_valid_ff;
   pab_rsp_type  rsp_data_ff, rsp_data_in;
   pab_cell_type last;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // register writes
   assign reg_sel = pab_reg_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      src_fmt_in = src_fmt_ff;
      dst_fmt_in = dst_fmt_ff;
      galpha_in  = galpha_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SRC_FMT: begin
               src_fmt_in = pwdata[0];
            end
            REG_DST_FMT: begin
               dst_fmt_in = pwdata[0];
            end
            REG_GALPHA: begin
               galpha_in = pwdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= FMT_RGB;
         dst_fmt_ff <= FMT_RGB;
         galpha_ff  <= 8'd255;
      end else begin
         src_fmt_ff <= src_fmt_in;
         dst_fmt_ff <= dst_fmt_in;
         galpha_ff  <= galpha_in;
      end
   end

   // register reads
   always_comb begin
      case (reg_sel)
         REG_SRC_FMT: prdata = {31'd0, src_fmt_ff};
         REG_DST_FMT: prdata = {31'd0, dst_fmt_ff};
         REG_GALPHA:  prdata = {24'd0, galpha_ff};
         default:     prdata = '0;
      endcase
   end

   assign cfg = '{src_fmt: src_fmt_ff, dst_fmt: dst_fmt_ff, galpha: galpha_ff};

   // front pipeline
   pab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // divider cell row
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      pab_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // result select
   assign last = chain_data[NUM_W];

   always_comb begin
      if (last.div) begin
         rsp_data_in.out_red   = last.work[0][7:0];
         rsp_data_in.out_green = last.work[1][7:0];
         rsp_data_in.out_blue  = last.work[2][7:0];
         rsp_data_in.out_alpha = last.oa;
      end else begin
         rsp_data_in.out_red   = last.fixed[0];
         rsp_data_in.out_green = last.fixed[1];
         rsp_data_in.out_blue  = last.fixed[2];
         rsp_data_in.out_alpha = last.fixed[3];
      end
      rsp_data_in.row_end_out = last.row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a global alpha write lands in the register
   a_galpha_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && reg_sel == REG_GALPHA) |=> (galpha_ff == $past(pwdata[7:0])))
      else $error("global alpha write lost");

   // a result strobe follows a valid word leaving the cell row
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(chain_valid[NUM_W]))
      else $error("result strobe without a word from the divider");

   // restoring remainder stays below the divisor on over-rule pixels
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[NUM_W] && last.div) |->
         (last.rem[0] < last.oa && last.rem[1] < last.oa && last.rem[2] < last.oa))
      else $error("divider remainder out of range");
`endif

endmodule

@@ src/pab_front.sv @@
// front pipeline: mode decode, products, divides by 255, over-rule numerator
module pab_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pab_pkg::pab_req_type in_data,
   input  pab_pkg::pab_cfg_type cfg,
   output logic                 out_valid,
   output pab_pkg::pab_cell_type out_data
);
   import pab_pkg::*;

   // reciprocal of 255 scaled by 2^23
   localparam logic [15:0] RECIP = 16'd32897;

   logic [FRONT_STAGES-1:0] valid_ff;
   logic [FRONT_STAGES-1:0] valid_in;

   // stage 1 registers
   pab_kind_type    kind1_ff, kind1_in;
   logic [7:0]      w1_ff, w1_in;
   logic [2:0][7:0] s1_ff, s1_in;
   logic [2:0][7:0] d1_ff, d1_in;
   logic [7:0]      da1_ff, da1_in;
   logic [3:0][7:0] fix1_ff, fix1_in;
   logic            re1_ff, re1_in;

   // stage 2 registers
   pab_kind_type     kind2_ff;
   logic [2:0][15:0] ps2_ff, ps2_in;
   logic [2:0][15:0] pd2_ff, pd2_in;
   logic [15:0]      pa2_ff, pa2_in;
   logic [7:0]       w2_ff, inv2_ff, da2_ff;
   logic [3:0][7:0]  fix2_ff;
   logic             re2_ff;

   // stage 3 registers
   pab_kind_type     kind3_ff;
   logic [2:0][15:0] sum3_ff, sum3_in;
   logic [2:0][23:0] pdi3_ff, pdi3_in;
   logic [15:0]      xa3_ff, xa3_in;
   logic [2:0][15:0] ps3_ff;
   logic [7:0]       w3_ff, da3_ff;
   logic [3:0][7:0]  fix3_ff;
   logic             re3_ff;

   // stage 4 registers
   pab_kind_type     kind4_ff;
   logic [2:0][7:0]  mq4_ff, mq4_in;
   logic [7:0]       oa4_ff, oa4_in;
   logic [2:0][16:0] est4_ff, est4_in;
   logic [2:0][23:0] pdi4_ff;
   logic [2:0][15:0] ps4_ff;
   logic [7:0]       da4_ff;
   logic [3:0][7:0]  fix4_ff;
   logic             re4_ff;

   // stage 5 register
   pab_cell_type     cell5_ff, cell5_in;

   logic [7:0]  inv1;
   logic [31:0] prod_a;
   logic [2:0][31:0] prod_m;
   logic [2:0][39:0] prod_q;
   logic [2:0][24:0] back;
   logic [2:0][16:0] q3;
   logic [2:0][16:0] num;

   assign valid_in = {valid_ff[FRONT_STAGES-2:0], in_valid};

   // mode decode
   always_comb begin
      s1_in  = {in_data.src_blue, in_data.src_green, in_data.src_red};
      d1_in  = {in_data.dst_blue, in_data.dst_green, in_data.dst_red};
      da1_in = in_data.dst_alpha;
      re1_in = in_data.row_end_in;
      kind1_in = KIND_MIX;
      w1_in  = cfg.galpha;
      fix1_in = {in_data.dst_alpha, in_data.dst_blue, in_data.dst_green, in_data.dst_red};
      if (cfg.src_fmt == cfg.dst_fmt && cfg.galpha == 8'd255) begin
         kind1_in = KIND_FIXED;
         fix1_in = {(cfg.src_fmt == FMT_RGBA) ? in_data.src_alpha : in_data.dst_alpha,
                    in_data.src_blue, in_data.src_green, in_data.src_red};
      end else if (cfg.src_fmt == FMT_RGBA && cfg.dst_fmt == FMT_RGBA) begin
         w1_in = in_data.src_alpha;
         if (in_data.src_alpha == 8'd0) begin
            kind1_in = KIND_FIXED;
         end else if (in_data.src_alpha == 8'd255 || in_data.dst_alpha == 8'd0) begin
            kind1_in = KIND_FIXED;
            fix1_in = {in_data.src_alpha, in_data.src_blue, in_data.src_green,
                       in_data.src_red};
         end else begin
            kind1_in = KIND_OVER;
         end
      end else if (cfg.src_fmt == FMT_RGBA) begin
         w1_in = in_data.src_alpha;
      end
   end

   // products
   always_comb begin
      inv1 = 8'd255 - w1_ff;
      for (int k = 0; k < 3; k++) begin
         ps2_in[k] = s1_ff[k] * w1_ff;
         pd2_in[k] = d1_ff[k] * ((kind1_ff == KIND_OVER) ? da1_ff : inv1);
      end
      pa2_in = da1_ff * inv1;
   end

   // sums and the scaled destination product
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum3_in[k] = ps2_ff[k] + pd2_ff[k] + 16'd127;
         pdi3_in[k] = pd2_ff[k] * inv2_ff + 24'd127;
      end
      xa3_in = pa2_ff + 16'd127;
   end

   // divide by 255 through the reciprocal
   always_comb begin
      prod_a = xa3_ff * RECIP;
      oa4_in = w3_ff + prod_a[30:23];
      for (int k = 0; k < 3; k++) begin
         prod_m[k]  = sum3_ff[k] * RECIP;
         mq4_in[k]  = prod_m[k][30:23];
         prod_q[k]  = pdi3_ff[k] * RECIP;
         est4_in[k] = prod_q[k][39:23];
      end
   end

   // estimate correction and numerator of the final divide
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         back[k] = {est4_ff[k], 8'd0} - {8'd0, est4_ff[k]};
         q3[k]   = (back[k] > {1'b0, pdi4_ff[k]}) ? est4_ff[k] - 17'd1 : est4_ff[k];
         num[k]  = {1'b0, ps4_ff[k]} + q3[k] + {10'd0, oa4_ff[7:1]};
      end
      cell5_in.div     = (kind4_ff == KIND_OVER);
      cell5_in.oa      = oa4_ff;
      cell5_in.rem     = '0;
      cell5_in.work    = {num[2][NUM_W-1:0], num[1][NUM_W-1:0], num[0][NUM_W-1:0]};
      cell5_in.fixed   = (kind4_ff == KIND_MIX) ? {da4_ff, mq4_ff} : fix4_ff;
      cell5_in.row_end = re4_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind1_ff <= kind1_in;
      w1_ff    <= w1_in;
      s1_ff    <= s1_in;
      d1_ff    <= d1_in;
      da1_ff   <= da1_in;
      fix1_ff  <= fix1_in;
      re1_ff   <= re1_in;

      kind2_ff <= kind1_ff;
      ps2_ff   <= ps2_in;
      pd2_ff   <= pd2_in;
      pa2_ff   <= pa2_in;
      w2_ff    <= w1_ff;
      inv2_ff  <= inv1;
      da2_ff   <= da1_ff;
      fix2_ff  <= fix1_ff;
      re2_ff   <= re1_ff;

      kind3_ff <= kind2_ff;
      sum3_ff  <= sum3_in;
      pdi3_ff  <= pdi3_in;
      xa3_ff   <= xa3_in;
      ps3_ff   <= ps2_ff;
      w3_ff    <= w2_ff;
      da3_ff   <= da2_ff;
      fix3_ff  <= fix2_ff;
      re3_ff   <= re2_ff;

      kind4_ff <= kind3_ff;
      mq4_ff   <= mq4_in;
      oa4_ff   <= oa4_in;
      est4_ff  <= est4_in;
      pdi4_ff  <= pdi3_ff;
      ps4_ff   <= ps3_ff;
      da4_ff   <= da3_ff;
      fix4_ff  <= fix3_ff;
      re4_ff   <= re3_ff;

      cell5_ff <= cell5_in;
   end

   assign out_valid = valid_ff[FRONT_STAGES-1];
   assign out_data  = cell5_ff;

endmodule

@@ src/pab_div_cell.sv @@
// one restoring divide step for the three colour channels
module pab_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pab_pkg::pab_cell_type in_data,
   output logic                  out_valid,
   output pab_pkg::pab_cell_type out_data
);
   import pab_pkg::*;

   logic         valid_ff;
   pab_cell_type data_ff, data_in;
   logic [2:0][8:0] trial;
   logic [2:0]      take;

   // shift in one numerator bit, subtract the divisor when it fits
   always_comb begin
      data_in = in_data;
      for (int k = 0; k < 3; k++) begin
         trial[k] = {in_data.rem[k], in_data.work[k][NUM_W-1]};
         take[k]  = (trial[k] >= {1'b0, in_data.oa});
         data_in.rem[k]  = take[k] ? 8'(trial[k] - {1'b0, in_data.oa}) : trial[k][7:0];
         data_in.work[k] = {in_data.work[k][NUM_W-2:0], take[k]};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ dv/tb_top.sv @@
// testbench for the pixel alpha blend block: directed and random pixels checked against a predictor
module tb_top;
   import pab_pkg::*;

   localparam int LATENCY   = 22;
   localparam int WDOG_MAX  = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   pab_req_type req_data;
   logic        rsp_valid;
   pab_rsp_type rsp_data;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor copy of the registers
   logic       cfg_src_fmt;
   logic       cfg_dst_fmt;
   logic [7:0] cfg_galpha;

   pab_rsp_type pixels_due[$];
   int          fail_count;
   int          idle_pct;
   int          quiet_cycles;

   pixel_alpha_blend dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // weighted blend of one channel
   function automatic logic [7:0] mix_chan(int unsigned s, int unsigned d, int unsigned a);
      if (a == 0) return d[7:0];
      if (a == 255) return s[7:0];
      return 8'((s * a + d * (255 - a) + 127) / 255);
   endfunction

   // expected result word for one pixel under the current registers
   function automatic pab_rsp_type blend_pixel(pab_req_type p);
      pab_rsp_type r;
      int unsigned s[3], d[3], sa, da, inv, oa, q;
      s[0] = p.src_red; s[1] = p.src_green; s[2] = p.src_blue;
      d[0] = p.dst_red; d[1] = p.dst_green; d[2] = p.dst_blue;
      sa = p.src_alpha; da = p.dst_alpha;
      r.out_red = p.dst_red; r.out_green = p.dst_green; r.out_blue = p.dst_blue;
      r.out_alpha = p.dst_alpha;
      r.row_end_out = p.row_end_in;
      if (cfg_src_fmt == cfg_dst_fmt && cfg_galpha == 8'd255) begin
         r.out_red = p.src_red; r.out_green = p.src_green; r.out_blue = p.src_blue;
         if (cfg_src_fmt == FMT_RGBA) r.out_alpha = p.src_alpha;
      end else if (cfg_src_fmt == FMT_RGBA && cfg_dst_fmt == FMT_RGBA) begin
         if (sa == 255 || (sa != 0 && da == 0)) begin
            r.out_red = p.src_red; r.out_green = p.src_green; r.out_blue = p.src_blue;
            r.out_alpha = p.src_alpha;
         end else if (sa != 0) begin
            inv = 255 - sa;
            oa = sa + (da * inv + 127) / 255;
            for (int k = 0; k < 3; k++) begin
               q = s[k] * sa + (d[k] * da * inv + 127) / 255;
               q = (q + oa / 2) / oa;
               if (k == 0) r.out_red = q[7:0];
               else if (k == 1) r.out_green = q[7:0];
               else r.out_blue = q[7:0];
            end
            r.out_alpha = (oa > 255) ? 8'd255 : oa[7:0];
         end
      end else begin
         q = (cfg_src_fmt == FMT_RGBA) ? sa : cfg_galpha;
         r.out_red   = mix_chan(s[0], d[0], q);
         r.out_green = mix_chan(s[1], d[1], q);
         r.out_blue  = mix_chan(s[2], d[2], q);
      end
      return r;
   endfunction

   // register write over the config port, block idle
   task automatic write_reg(pab_reg_type idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = 4'(idx) << 2; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SRC_FMT: cfg_src_fmt = val[0];
         REG_DST_FMT: cfg_dst_fmt = val[0];
         REG_GALPHA:  cfg_galpha  = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // wait for all pixels in flight, then change the setup
   task automatic set_mode(logic sf, logic df, logic [7:0] ga);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      write_reg(REG_SRC_FMT, {$urandom} & 32'hFFFF_FFFE | sf);
      write_reg(REG_DST_FMT, {31'd0, df});
      write_reg(REG_GALPHA, {24'd0, ga});
   endtask

   // send one pixel word, with random idle gaps; entered and left at a falling edge
   task automatic send_pixel(pab_req_type p);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_data = p;
      do @(posedge clock); while (busy);
      pixels_due.push_back(blend_pixel(p));
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic pab_req_type rand_pixel();
      pab_req_type p;
      p = pab_req_type'({$urandom, $urandom, 1'($urandom)});
      // bias alphas toward their shortcut values
      case ($urandom_range(7))
         0: p.src_alpha = 8'd0;
         1: p.src_alpha = 8'd255;
         2: p.dst_alpha = 8'd0;
         3: p.dst_alpha = 8'd255;
         default: ;
      endcase
      return p;
   endfunction

   task automatic test_extremes();
      pab_req_type p;
      set_mode(FMT_RGBA, FMT_RGBA, 8'd128);
      p = '0; send_pixel(p);
      p = '1; send_pixel(p);
      p = '0; p.src_alpha = 8'd0; p.dst_red = 8'hff; p.dst_alpha = 8'd77; send_pixel(p);
      p = '1; p.src_alpha = 8'd255; p.dst_alpha = 8'd10; send_pixel(p);
      p = '1; p.src_alpha = 8'd90; p.dst_alpha = 8'd0; send_pixel(p);
      p = '1; p.src_alpha = 8'd1; p.dst_alpha = 8'd1; send_pixel(p);
      p = '1; p.src_alpha = 8'd254; p.dst_alpha = 8'd254; send_pixel(p);
      p = '0; p.src_red = 8'd255; p.src_alpha = 8'd1; p.dst_alpha = 8'd255; send_pixel(p);
   endtask

   task automatic test_copy_modes();
      pab_req_type p;
      set_mode(FMT_RGBA, FMT_RGBA, 8'd255);
      p = '0; p.src_red = 8'd200; p.src_alpha = 8'd0; p.dst_alpha = 8'd99; send_pixel(p);
      set_mode(FMT_RGB, FMT_RGB, 8'd255);
      p = '1; p.src_green = 8'd3; p.dst_alpha = 8'd44; send_pixel(p);
      set_mode(FMT_RGB, FMT_RGB, 8'd0);
      p = '1; p.dst_red = 8'd5; send_pixel(p);
      set_mode(FMT_RGB, FMT_RGBA, 8'd255);
      p = '1; p.dst_alpha = 8'd17; p.dst_blue = 8'd0; send_pixel(p);
      set_mode(FMT_RGBA, FMT_RGB, 8'd255);
      p = '1; p.src_alpha = 8'd0; p.dst_green = 8'd1; send_pixel(p);
      p = '1; p.src_alpha = 8'd255; p.src_blue = 8'd2; send_pixel(p);
      p = '1; p.src_alpha = 8'd128; p.dst_red = 8'd0; send_pixel(p);
      set_mode(FMT_RGB, FMT_RGB, 8'd1);
      p = '1; p.dst_red = 8'd0; send_pixel(p);
   endtask

   task automatic test_random();
      logic [7:0] ga;
      for (int phase = 0; phase < 20; phase++) begin
         case ($urandom_range(3))
            0: ga = 8'd0;
            1: ga = 8'd255;
            default: ga = 8'($urandom);
         endcase
         set_mode(1'($urandom), 1'($urandom), ga);
         idle_pct = (phase == 7) ? 0 : 23;
         for (int n = 0; n < 100; n++) send_pixel(rand_pixel());
      end
   endtask

   // result checker
   always @(posedge clock) begin
      pab_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pixels_due.size() == 0) begin
            $display("%0t unexpected word: actual %p", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = pixels_due.pop_front();
            if (rsp_data !== want) begin
               $display("%0t mismatch: expected %p actual %p", $realtime, want, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("pixel_alpha_blend verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1; start = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cfg_src_fmt = FMT_RGB; cfg_dst_fmt = FMT_RGB; cfg_galpha = 8'd255;
      fail_count = 0; idle_pct = 23; quiet_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_copy_modes();
      test_random();
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (fail_count == 0 && pixels_due.size() == 0) begin
         $display("pixel_alpha_blend verification clean");
      end else begin
         $display("pixel_alpha_blend verification failed");
      end
      $finish;
   end

endmodule
